/* design/psn_pkg.sv */
// ----------------------------------------------------------------------------
// psn_pkg: shared types and constants for the primitive surface normal unit
// Widths, fixed-point formats, codes and the pipeline item record.
// ----------------------------------------------------------------------------
package psn_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int DIR_FRAC_BITS   = 19;
  localparam int OUT_FRAC        = 14;

  localparam int CFGW     = 63;
  localparam int CFG_IDXW = 3;
  localparam int DIRW     = 21;
  localparam int CRDW     = 32;
  localparam int LENW     = 31;
  localparam int OW       = 16;

  localparam int DW    = CRDW + 1;
  localparam int PPW   = 2 * DIRW;
  localparam int ZPW   = DW + DIRW;
  localparam int ZSW   = ZPW + 2;
  localparam int ZCW   = 32;
  localparam int DPW   = ZCW + DIRW;
  localparam int MAGW  = 54;
  localparam int NGRP  = (MAGW + 7) / 8;
  localparam int SHW   = 6;
  localparam int NORM_MSB = 29;
  localparam int NW    = NORM_MSB + 1;
  localparam int SQW   = 2 * NW + 2;
  localparam int RTW   = NW + 1;
  localparam int QW    = OUT_FRAC + 1;
  localparam int NUMW  = NW + OUT_FRAC + 2;

  localparam int SQ_STEPS  = 2;
  localparam int DIV_STEPS = 3;

  localparam longint unsigned DEGEN_THR =
    ((64'd1 << (COORD_FRAC_BITS + DIR_FRAC_BITS)) + 64'd50000) / 64'd100000;
  localparam longint unsigned DEGEN_THR2 = DEGEN_THR * DEGEN_THR;
  localparam int THR_W = $clog2(DEGEN_THR + 1);
  localparam int LSQW  = 2 * THR_W;

  localparam logic [CFGW-1:0] POSE_X_RST = CFGW'(64'd1 << DIR_FRAC_BITS);
  localparam logic [CFGW-1:0] POSE_Y_RST = CFGW'(64'd1 << (DIR_FRAC_BITS + DIRW));
  localparam logic [CFGW-1:0] POSE_Z_RST = CFGW'(64'd1 << (DIR_FRAC_BITS + 2 * DIRW));

  typedef enum logic [1:0] {
    OP_PLANE       = 2'd0,
    OP_CAPSULE     = 2'd1,
    OP_NEG_CAPSULE = 2'd2,
    OP_UNSUP       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_UNSUP = 2'd2
  } status_e;

  typedef enum logic [CFG_IDXW-1:0] {
    CFG_POSE_X   = 3'd0,
    CFG_POSE_Y   = 3'd1,
    CFG_POSE_Z   = 3'd2,
    CFG_LOCAL_N  = 3'd3,
    CFG_CENTER_X = 3'd4,
    CFG_CENTER_Y = 3'd5,
    CFG_CENTER_Z = 3'd6,
    CFG_LENGTH   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    op_e                         op;
    logic [2:0][DW-1:0]          d;
    logic [2:0][2:0][PPW-1:0]    pp;
    logic [2:0][OW-1:0]          pl;
    logic [2:0][ZPW-1:0]         zp;
    logic [ZCW-1:0]              zc;
    logic [2:0][DPW-1:0]         dp;
    logic [2:0]                  neg;
    logic [2:0][MAGW-1:0]        mag;
    logic [MAGW-1:0]             m;
    logic                        below_thr;
    logic [2:0][LSQW-1:0]        lsq;
    logic                        degen;
    logic [NGRP-1:0]             gnz;
    logic [NGRP-1:0][2:0]        goff;
    logic                        sh_r;
    logic [SHW-1:0]              shamt;
    logic [2:0][NW-1:0]          mn;
    logic [2:0][2*NW-1:0]        sq3;
    logic [SQW-1:0]              sq;
    logic [RTW-1:0]              nrm;
    logic [2:0][QW-1:0]          q;
  } item_t;

  function automatic logic signed [DIRW-1:0] dcomp(input logic [CFGW-1:0] r, input int k);
    return $signed(r[DIRW*k +: DIRW]);
  endfunction

endpackage

/* design/psn_isqrt.sv */
// ----------------------------------------------------------------------------
// psn_isqrt: pipelined integer square root
// Digit recurrence, a fixed number of root bits per register stage.
// ----------------------------------------------------------------------------
module psn_isqrt (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  psn_pkg::item_t item_i,
  output logic          valid_o,
  output psn_pkg::item_t item_o
);

  localparam int NS = (psn_pkg::RTW + psn_pkg::SQ_STEPS - 1) / psn_pkg::SQ_STEPS;
  localparam int SQW = psn_pkg::SQW;
  localparam int RTW = psn_pkg::RTW;

  logic [NS-1:0]  v_q;
  logic [SQW-1:0] rem_d  [NS];
  logic [SQW-1:0] rem_q  [NS];
  logic [RTW-1:0] root_d [NS];
  logic [RTW-1:0] root_q [NS];
  psn_pkg::item_t it_q   [NS];

  always_comb begin
    logic [SQW-1:0] r;
    logic [RTW-1:0] q;
    logic [SQW:0]   t;
    int             bi;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        r = item_i.sq;
        q = '0;
      end else begin
        r = rem_q[k-1];
        q = root_q[k-1];
      end
      for (int s = 0; s < psn_pkg::SQ_STEPS; s++) begin
        bi = RTW - 1 - (k * psn_pkg::SQ_STEPS + s);
        if (bi >= 0) begin
          t = ((SQW+1)'(q) << (bi + 1)) | ((SQW+1)'(1) << (2 * bi));
          if ({1'b0, r} >= t) begin
            r = r - t[SQW-1:0];
            q = q | (RTW'(1) << bi);
          end
        end
      end
      rem_d[k]  = r;
      root_d[k] = q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        it_q[k]   <= (k == 0) ? item_i : it_q[k-1];
      end
    end
  end

  assign valid_o = v_q[NS-1];

  always_comb begin
    item_o     = it_q[NS-1];
    item_o.nrm = root_q[NS-1];
  end

endmodule

/* design/psn_div.sv */
// ----------------------------------------------------------------------------
// psn_div: pipelined restoring divider for the three normal components
// One prep stage forms the rounded numerators, then a few quotient bits per
// stage.
// ----------------------------------------------------------------------------
module psn_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  psn_pkg::item_t item_i,
  output logic          valid_o,
  output psn_pkg::item_t item_o
);

  localparam int DNS  = (psn_pkg::QW + psn_pkg::DIV_STEPS - 1) / psn_pkg::DIV_STEPS;
  localparam int NUMW = psn_pkg::NUMW;
  localparam int QW   = psn_pkg::QW;
  localparam int RTW  = psn_pkg::RTW;

  logic [DNS:0]              v_q;
  logic [2:0][NUMW-1:0]      num_d [DNS+1];
  logic [2:0][NUMW-1:0]      num_q [DNS+1];
  logic [2:0][QW-1:0]        quo_d [DNS+1];
  logic [2:0][QW-1:0]        quo_q [DNS+1];
  logic [RTW-1:0]            den_q [DNS+1];
  psn_pkg::item_t            it_q  [DNS+1];

  always_comb begin
    logic [2:0][NUMW-1:0] r;
    logic [2:0][QW-1:0]   q;
    logic [NUMW-1:0]      t;
    int                   bi;
    for (int i = 0; i < 3; i++) begin
      num_d[0][i] = (NUMW'(item_i.mn[i]) << psn_pkg::OUT_FRAC) + NUMW'(item_i.nrm >> 1);
    end
    quo_d[0] = '0;
    for (int k = 1; k <= DNS; k++) begin
      r = num_q[k-1];
      q = quo_q[k-1];
      for (int s = 0; s < psn_pkg::DIV_STEPS; s++) begin
        bi = QW - 1 - ((k - 1) * psn_pkg::DIV_STEPS + s);
        if (bi >= 0) begin
          t = NUMW'(den_q[k-1]) << bi;
          for (int i = 0; i < 3; i++) begin
            if (r[i] >= t) begin
              r[i] = r[i] - t;
              q[i] = q[i] | (QW'(1) << bi);
            end
          end
        end
      end
      num_d[k] = r;
      quo_d[k] = q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DNS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= DNS; k++) begin
        num_q[k] <= num_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= (k == 0) ? item_i.nrm : den_q[k-1];
        it_q[k]  <= (k == 0) ? item_i : it_q[k-1];
      end
    end
  end

  assign valid_o = v_q[DNS];

  always_comb begin
    item_o   = it_q[DNS];
    item_o.q = quo_q[DNS];
  end

endmodule

/* design/primitive_surface_normal_unit.sv */
// ----------------------------------------------------------------------------
// primitive_surface_normal_unit: outward surface normal of a plane or capsule
// Structure: 11 front stages, 16 square-root stages, 6 divider stages and an
//   output register.
// Throughput: one beat per cycle; the whole pipeline holds while the output
//   beat is stalled. Reset clears all valid bits and loads identity pose,
//   +z local normal, zero center and zero length.
// ----------------------------------------------------------------------------
module primitive_surface_normal_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [psn_pkg::CFG_IDXW-1:0]        cfg_idx_i,
  input  logic [psn_pkg::CFGW-1:0]            cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          op_i,
  input  logic signed [psn_pkg::CRDW-1:0]     point_x_i,
  input  logic signed [psn_pkg::CRDW-1:0]     point_y_i,
  input  logic signed [psn_pkg::CRDW-1:0]     point_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [psn_pkg::OW-1:0]       normal_x_o,
  output logic signed [psn_pkg::OW-1:0]       normal_y_o,
  output logic signed [psn_pkg::OW-1:0]       normal_z_o,
  output logic [1:0]                          status_o
);

  localparam int NFR  = 11;
  localparam int D    = psn_pkg::DIR_FRAC_BITS;
  localparam int OW   = psn_pkg::OW;
  localparam int PLAW = psn_pkg::PPW + 3;
  localparam int PLSH = 2 * D - psn_pkg::OUT_FRAC;
  localparam int ZSW  = psn_pkg::ZSW;
  localparam int MAGW = psn_pkg::MAGW;
  localparam int SHW  = psn_pkg::SHW;
  localparam int LSUMW = psn_pkg::LSQW + 2;
  localparam logic signed [PLAW-1:0] PL_HALF = PLAW'(64'd1 << (PLSH - 1));
  localparam logic signed [ZSW-1:0]  Z_HALF  = ZSW'(64'd1 << (D - 1));

  logic [psn_pkg::CFGW-1:0]      pose_q [3];
  logic [psn_pkg::CFGW-1:0]      lnrm_q;
  logic [psn_pkg::CRDW-1:0]      center_q [3];
  logic [psn_pkg::LENW-1:0]      len_q;

  logic                          en;
  logic [NFR-1:0]                v_q;
  psn_pkg::item_t                st_d [NFR];
  psn_pkg::item_t                st_q [NFR];

  logic                          sq_v;
  psn_pkg::item_t                sq_item;
  logic                          dv_v;
  psn_pkg::item_t                dv_item;

  logic                          out_v_q;
  logic [OW-1:0]                 nx_d, ny_d, nz_d;
  logic [OW-1:0]                 nx_q, ny_q, nz_q;
  psn_pkg::status_e              st_code_d, st_code_q;

  function automatic logic [OW-1:0] sat_out(input logic signed [PLAW-1:0] v);
    if (v[PLAW-1:OW-1] == '0 || v[PLAW-1:OW-1] == '1) begin
      return v[OW-1:0];
    end
    return v[PLAW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
  endfunction

  function automatic logic [2:0] msb8(input logic [7:0] b);
    logic [2:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = 3'(i);
    end
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_q[0]   <= psn_pkg::POSE_X_RST;
      pose_q[1]   <= psn_pkg::POSE_Y_RST;
      pose_q[2]   <= psn_pkg::POSE_Z_RST;
      lnrm_q      <= psn_pkg::POSE_Z_RST;
      center_q[0] <= '0;
      center_q[1] <= '0;
      center_q[2] <= '0;
      len_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (psn_pkg::cfg_idx_e'(cfg_idx_i))
        psn_pkg::CFG_POSE_X:   pose_q[0]   <= cfg_wdata_i;
        psn_pkg::CFG_POSE_Y:   pose_q[1]   <= cfg_wdata_i;
        psn_pkg::CFG_POSE_Z:   pose_q[2]   <= cfg_wdata_i;
        psn_pkg::CFG_LOCAL_N:  lnrm_q      <= cfg_wdata_i;
        psn_pkg::CFG_CENTER_X: center_q[0] <= cfg_wdata_i[psn_pkg::CRDW-1:0];
        psn_pkg::CFG_CENTER_Y: center_q[1] <= cfg_wdata_i[psn_pkg::CRDW-1:0];
        psn_pkg::CFG_CENTER_Z: center_q[2] <= cfg_wdata_i[psn_pkg::CRDW-1:0];
        psn_pkg::CFG_LENGTH:   len_q       <= cfg_wdata_i[psn_pkg::LENW-1:0];
        default: ;
      endcase
    end
  end

  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  // stage 0: offsets from the center, plane products
  always_comb begin
    logic signed [psn_pkg::PPW-1:0] a, b;
    st_d[0]      = '0;
    st_d[0].op   = psn_pkg::op_e'(op_i);
    st_d[0].d[0] = {point_x_i[psn_pkg::CRDW-1], point_x_i}
                 - {center_q[0][psn_pkg::CRDW-1], center_q[0]};
    st_d[0].d[1] = {point_y_i[psn_pkg::CRDW-1], point_y_i}
                 - {center_q[1][psn_pkg::CRDW-1], center_q[1]};
    st_d[0].d[2] = {point_z_i[psn_pkg::CRDW-1], point_z_i}
                 - {center_q[2][psn_pkg::CRDW-1], center_q[2]};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        a = psn_pkg::dcomp(pose_q[j], i);
        b = psn_pkg::dcomp(lnrm_q, j);
        st_d[0].pp[i][j] = a * b;
      end
    end
  end

  // stage 1: axis projection products, plane sum with rounding
  always_comb begin
    logic signed [psn_pkg::ZPW-1:0] a, b;
    logic signed [PLAW-1:0]         acc;
    st_d[1] = st_q[0];
    for (int i = 0; i < 3; i++) begin
      a = $signed(st_q[0].d[i]);
      b = psn_pkg::dcomp(pose_q[0], i);
      st_d[1].zp[i] = a * b;
      acc = $signed(st_q[0].pp[i][0]);
      acc = acc + $signed(st_q[0].pp[i][1]) + $signed(st_q[0].pp[i][2]) + PL_HALF;
      st_d[1].pl[i] = sat_out(acc >>> PLSH);
    end
  end

  // stage 2: clamp the projection to the segment, round to coordinate scale
  always_comb begin
    logic signed [ZSW-1:0] z, hl;
    st_d[2] = st_q[1];
    z = $signed(st_q[1].zp[0]);
    z = z + $signed(st_q[1].zp[1]) + $signed(st_q[1].zp[2]);
    hl = $signed(ZSW'(len_q) << (D - 1));
    if (z > hl) z = hl;
    if (z < -hl) z = -hl;
    z = (z + Z_HALF) >>> D;
    st_d[2].zc = z[psn_pkg::ZCW-1:0];
  end

  // stage 3: axis point products
  always_comb begin
    logic signed [psn_pkg::DPW-1:0] a, b;
    st_d[3] = st_q[2];
    for (int i = 0; i < 3; i++) begin
      a = $signed(st_q[2].zc);
      b = psn_pkg::dcomp(pose_q[0], i);
      st_d[3].dp[i] = a * b;
    end
  end

  // stage 4: direction, sign and magnitude
  always_comb begin
    logic signed [MAGW-1:0] ds, dps, dir;
    st_d[4] = st_q[3];
    for (int i = 0; i < 3; i++) begin
      ds  = $signed(st_q[3].d[i]);
      dps = $signed(st_q[3].dp[i]);
      dir = (ds <<< D) - dps;
      if (st_q[3].op == psn_pkg::OP_NEG_CAPSULE) dir = -dir;
      st_d[4].neg[i] = dir[MAGW-1];
      st_d[4].mag[i] = dir[MAGW-1] ? MAGW'(-dir) : MAGW'(dir);
    end
  end

  // stage 5: largest magnitude, small-vector squares
  always_comb begin
    logic [MAGW-1:0]             m;
    logic [psn_pkg::THR_W-1:0]   lo;
    st_d[5] = st_q[4];
    m = st_q[4].mag[0];
    if (st_q[4].mag[1] > m) m = st_q[4].mag[1];
    if (st_q[4].mag[2] > m) m = st_q[4].mag[2];
    st_d[5].m         = m;
    st_d[5].below_thr = (m < MAGW'(psn_pkg::DEGEN_THR));
    for (int i = 0; i < 3; i++) begin
      lo = st_q[4].mag[i][psn_pkg::THR_W-1:0];
      st_d[5].lsq[i] = psn_pkg::LSQW'(lo) * psn_pkg::LSQW'(lo);
    end
  end

  // stage 6: degenerate test, per-byte leading one of the largest magnitude
  always_comb begin
    logic [LSUMW-1:0]             s;
    logic [psn_pkg::NGRP*8-1:0]   mpad;
    st_d[6] = st_q[5];
    s = LSUMW'(st_q[5].lsq[0]) + LSUMW'(st_q[5].lsq[1]) + LSUMW'(st_q[5].lsq[2]);
    st_d[6].degen = st_q[5].below_thr && (s < LSUMW'(psn_pkg::DEGEN_THR2));
    mpad = (psn_pkg::NGRP*8)'(st_q[5].m);
    for (int g = 0; g < psn_pkg::NGRP; g++) begin
      st_d[6].gnz[g]  = |mpad[8*g +: 8];
      st_d[6].goff[g] = msb8(mpad[8*g +: 8]);
    end
  end

  // stage 7: leading one position, normalize shift
  always_comb begin
    logic [SHW-1:0] msb;
    st_d[7] = st_q[6];
    msb = '0;
    for (int g = 0; g < psn_pkg::NGRP; g++) begin
      if (st_q[6].gnz[g]) msb = SHW'(8 * g) + SHW'(st_q[6].goff[g]);
    end
    if (msb > SHW'(psn_pkg::NORM_MSB)) begin
      st_d[7].sh_r  = 1'b1;
      st_d[7].shamt = msb - SHW'(psn_pkg::NORM_MSB);
    end else begin
      st_d[7].sh_r  = 1'b0;
      st_d[7].shamt = SHW'(psn_pkg::NORM_MSB) - msb;
    end
  end

  // stage 8: apply the normalize shift
  always_comb begin
    logic [MAGW-1:0] sh;
    st_d[8] = st_q[7];
    for (int i = 0; i < 3; i++) begin
      sh = st_q[7].sh_r ? (st_q[7].mag[i] >> st_q[7].shamt)
                        : (st_q[7].mag[i] << st_q[7].shamt);
      st_d[8].mn[i] = sh[psn_pkg::NW-1:0];
    end
  end

  // stage 9: squares
  always_comb begin
    st_d[9] = st_q[8];
    for (int i = 0; i < 3; i++) begin
      st_d[9].sq3[i] = (2*psn_pkg::NW)'(st_q[8].mn[i]) * (2*psn_pkg::NW)'(st_q[8].mn[i]);
    end
  end

  // stage 10: sum of squares
  always_comb begin
    st_d[10]    = st_q[9];
    st_d[10].sq = psn_pkg::SQW'(st_q[9].sq3[0]) + psn_pkg::SQW'(st_q[9].sq3[1])
                + psn_pkg::SQW'(st_q[9].sq3[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NFR-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NFR; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  psn_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[NFR-1]),
    .item_i  (st_q[NFR-1]),
    .valid_o (sq_v),
    .item_o  (sq_item)
  );

  psn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .item_i  (sq_item),
    .valid_o (dv_v),
    .item_o  (dv_item)
  );

  // output select
  always_comb begin
    logic [2:0][OW-1:0] cap;
    for (int i = 0; i < 3; i++) begin
      cap[i] = dv_item.neg[i] ? -OW'(dv_item.q[i]) : OW'(dv_item.q[i]);
    end
    nx_d      = '0;
    ny_d      = '0;
    nz_d      = '0;
    st_code_d = psn_pkg::ST_OK;
    unique case (dv_item.op)
      psn_pkg::OP_PLANE: begin
        nx_d = dv_item.pl[0];
        ny_d = dv_item.pl[1];
        nz_d = dv_item.pl[2];
      end
      psn_pkg::OP_CAPSULE, psn_pkg::OP_NEG_CAPSULE: begin
        if (dv_item.degen) begin
          st_code_d = psn_pkg::ST_DEGEN;
        end else begin
          nx_d = cap[0];
          ny_d = cap[1];
          nz_d = cap[2];
        end
      end
      default: begin
        st_code_d = psn_pkg::ST_UNSUP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q      <= nx_d;
      ny_q      <= ny_d;
      nz_q      <= nz_d;
      st_code_q <= st_code_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign normal_x_o  = $signed(nx_q);
  assign normal_y_o  = $signed(ny_q);
  assign normal_z_o  = $signed(nz_q);
  assign status_o    = st_code_q;

endmodule

/* design/psn_checker.sv */
// ----------------------------------------------------------------------------
// psn_checker: port-level checks for the primitive surface normal unit
// Bound to the top level; watches handshake and result coding over time.
// ----------------------------------------------------------------------------
module psn_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [psn_pkg::OW-1:0] normal_x_o,
  input logic signed [psn_pkg::OW-1:0] normal_y_o,
  input logic signed [psn_pkg::OW-1:0] normal_z_o,
  input logic [1:0]                    status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(normal_x_o)
      && $stable(normal_y_o) && $stable(normal_z_o) && $stable(status_o))
    else $error("stalled output beat changed");

  a_stall_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output stall");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != psn_pkg::ST_OK |->
      normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("non-ok status with nonzero normal");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind primitive_surface_normal_unit psn_checker u_psn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .normal_x_o  (normal_x_o),
  .normal_y_o  (normal_y_o),
  .normal_z_o  (normal_z_o),
  .status_o    (status_o)
);
